// File: design/spq_pkg.sv
// Shared definitions for the sorted priority queue: default sizes, action and
// status codes, and the control and link structs passed between the cells.
// No dependencies.
package spq_pkg;

	localparam int DEPTH_DEFAULT          = 16;
	localparam int PAYLOAD_WIDTH_DEFAULT  = 32;
	localparam int PRIORITY_WIDTH_DEFAULT = 16;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// Operation broadcast to every cell in the cycle a word is taken.
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

	// What a cell tells its neighbor about itself.
	typedef struct packed {
		logic valid;
		logic ge;
	} cell_stat_t;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell #(
	parameter int PAYLOAD_WIDTH  = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::cell_ctrl_t              ctrl,
	input  logic signed [PRIORITY_WIDTH-1:0] new_prio,
	input  logic        [PAYLOAD_WIDTH-1:0]  new_payload,
	input  spq_pkg::cell_stat_t              left_stat,
	input  logic signed [PRIORITY_WIDTH-1:0] left_prio,
	input  logic        [PAYLOAD_WIDTH-1:0]  left_payload,
	input  logic                             right_valid,
	input  logic signed [PRIORITY_WIDTH-1:0] right_prio,
	input  logic        [PAYLOAD_WIDTH-1:0]  right_payload,
	output spq_pkg::cell_stat_t              stat,
	output logic signed [PRIORITY_WIDTH-1:0] prio,
	output logic        [PAYLOAD_WIDTH-1:0]  payload
);

	logic                             valid_q;
	logic signed [PRIORITY_WIDTH-1:0] prio_q;
	logic        [PAYLOAD_WIDTH-1:0]  payload_q;
	logic                             ge;

	// Entries at or above the new priority stay put, keeping arrival order.
	assign ge = valid_q && (prio_q >= new_prio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | left_stat.valid;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !ge) begin
			if (left_stat.ge) begin
				prio_q    <= new_prio;
				payload_q <= new_payload;
			end else begin
				prio_q    <= left_prio;
				payload_q <= left_payload;
			end
		end else if (ctrl.pop) begin
			prio_q    <= right_prio;
			payload_q <= right_payload;
		end
	end

	assign stat.valid = valid_q;
	assign stat.ge    = ge;
	assign prio       = prio_q;
	assign payload    = payload_q;

endmodule

// File: design/sorted_priority_queue_top.sv
// Sorted priority queue: a chain of DEPTH cells kept in priority order.
// A word's result is registered and shows in the cycle after it is taken.
// Throughput: one insert or pop per cycle while out_ready drains the result;
// each cell compares and shifts as a word is taken, and a held result stalls in_ready.
// Reset empties the queue at once; entry contents are left undefined.
module sorted_priority_queue_top #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEFAULT,
	parameter int PAYLOAD_WIDTH  = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEFAULT,
	localparam int CNT_W         = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic        [PAYLOAD_WIDTH-1:0]    element_payload,
	input  logic signed [PRIORITY_WIDTH-1:0]   entry_priority,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic        [PAYLOAD_WIDTH-1:0]    popped_payload,
	output logic        [spq_pkg::STATUS_W-1:0] status,
	output logic        [CNT_W-1:0]            occupancy
);

	// Number of held entries; the cells also carry their own valid bits,
	// but the count gives full and empty without scanning the chain.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	logic                                out_valid_q;
	logic [PAYLOAD_WIDTH-1:0]            popped_q;
	logic [spq_pkg::STATUS_W-1:0]        status_q;
	logic [CNT_W-1:0]                    occupancy_q;

	logic                                take;
	logic                                full;
	logic                                empty;
	logic [PAYLOAD_WIDTH-1:0]            popped_next;
	logic [spq_pkg::STATUS_W-1:0]        status_next;
	spq_pkg::cell_ctrl_t                 ctrl;

	spq_pkg::cell_stat_t                 cell_stat    [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0]    cell_prio    [DEPTH];
	logic        [PAYLOAD_WIDTH-1:0]     cell_payload [DEPTH];

	// A new word is taken whenever the result register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Decide the operation and the result. Refused inserts and pops on an
	// empty queue leave the chain untouched and only report a status.
	always_comb begin
		ctrl.ins    = 1'b0;
		ctrl.pop    = 1'b0;
		popped_next = '0;
		status_next = spq_pkg::STATUS_OK;
		count_next  = count_q;
		if (action == spq_pkg::ACT_INSERT) begin
			if (full) begin
				status_next = spq_pkg::STATUS_FULL;
			end else begin
				ctrl.ins   = take;
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_next = spq_pkg::STATUS_EMPTY;
			end else begin
				ctrl.pop    = take;
				popped_next = cell_payload[0];
				count_next  = count_q - CNT_W'(1);
			end
		end
	end

	// The chain itself. The head cell sees a virtual left neighbor that is
	// always valid and always outranks the new entry, so an insert that beats
	// every held entry lands there. The tail cell's right neighbor is empty.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::cell_stat_t              left_stat;
		logic signed [PRIORITY_WIDTH-1:0] left_prio;
		logic        [PAYLOAD_WIDTH-1:0]  left_payload;
		logic                             right_valid;
		logic signed [PRIORITY_WIDTH-1:0] right_prio;
		logic        [PAYLOAD_WIDTH-1:0]  right_payload;

		if (i == 0) begin : g_head
			assign left_stat.valid = 1'b1;
			assign left_stat.ge    = 1'b1;
			assign left_prio       = entry_priority;
			assign left_payload    = element_payload;
		end else begin : g_body
			assign left_stat    = cell_stat[i-1];
			assign left_prio    = cell_prio[i-1];
			assign left_payload = cell_payload[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_valid   = 1'b0;
			assign right_prio    = entry_priority;
			assign right_payload = element_payload;
		end else begin : g_inner
			assign right_valid   = cell_stat[i+1].valid;
			assign right_prio    = cell_prio[i+1];
			assign right_payload = cell_payload[i+1];
		end

		spq_cell #(
			.PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
			.PRIORITY_WIDTH (PRIORITY_WIDTH)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.new_prio      (entry_priority),
			.new_payload   (element_payload),
			.left_stat     (left_stat),
			.left_prio     (left_prio),
			.left_payload  (left_payload),
			.right_valid   (right_valid),
			.right_prio    (right_prio),
			.right_payload (right_payload),
			.stat          (cell_stat[i]),
			.prio          (cell_prio[i]),
			.payload       (cell_payload[i])
		);
	end

	// Control state: occupancy count and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload, status and occupancy registers, loaded with each taken word.
	always_ff @(posedge clk) begin
		if (take) begin
			popped_q    <= popped_next;
			status_q    <= status_next;
			occupancy_q <= count_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign popped_payload = popped_q;
	assign status         = status_q;
	assign occupancy      = occupancy_q;

endmodule
